[rtl/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
// No dependencies; compiled first.

package spq_pkg;

   localparam int TAG_W  = 16;
   localparam int PRIO_W = 2;
   localparam int OCC_W  = 4;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_SERVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_ADDED  = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_SERVED = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // per-cell controls
   typedef struct packed {
      logic load;
      logic advance;
   } cell_ctl_type;

   // controller to cell row
   typedef struct packed {
      logic load_en;
      logic scan_en;
      logic shift_en;
   } ctrl_type;

endpackage

[rtl/spq_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on spq_pkg.

interface spq_req_if import spq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [TAG_W-1:0]  request_tag;
   logic [PRIO_W-1:0] request_priority;

   modport source (output valid, action, request_tag, request_priority, input ready);
   modport sink   (input valid, action, request_tag, request_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [TAG_W-1:0]  served_tag;
   logic [PRIO_W-1:0] served_priority;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, status, served_tag, served_priority, occupancy, input ready);
   modport sink   (input valid, status, served_tag, served_priority, occupancy, output ready);
endinterface

[rtl/spq_cell.sv]
// One queue cell: holds a single entry, loads a new one or takes its neighbor's.
// Depends on spq_pkg.

module spq_cell import spq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    load_data,
   input  entry_type    next_data,
   output entry_type    data
);

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.advance) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/spq_ctrl.sv]
// Sequencer: handshakes, occupancy count, ring scan for the best entry, response register.
// Depends on spq_pkg and spq_if.

module spq_ctrl import spq_pkg::*; #(
   parameter  int QUEUE_DEPTH = 8,
   localparam int CW = $clog2(QUEUE_DEPTH + 1),
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   spq_req_if.sink       req_chan,
   spq_rsp_if.source     rsp_chan,
   input  entry_type     head,
   output ctrl_type      ctrl,
   output logic [CW-1:0] count,
   output logic [IW-1:0] best
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     scan_ff, scan_in;
   logic [IW-1:0]     best_ff, best_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   status_type        pend_status_ff, pend_status_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic [PRIO_W-1:0] pend_prio_ff, pend_prio_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic accept;
   logic is_add;
   logic full;
   logic scan_last;
   logic scan_take;
   logic out_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_add    = (req_chan.action == ACT_ADD);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign scan_last = (scan_ff == IW'(QUEUE_DEPTH - 1));
   // first entry always wins, later ones only on strictly smaller priority
   assign scan_take = (scan_ff == '0) ||
                      ((CW'(scan_ff) < count_ff) && (head.prio < best_prio_ff));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      best_in        = best_ff;
      best_prio_in   = best_prio_ff;
      pend_status_in = pend_status_ff;
      pend_tag_in    = pend_tag_ff;
      pend_prio_in   = pend_prio_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_occ_in     = rsp_occ_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_tag_in  = '0;
               pend_prio_in = '0;
               if (is_add) begin
                  if (full) begin
                     pend_status_in = STAT_FULL;
                  end else begin
                     pend_status_in = STAT_ADDED;
                     count_in       = count_ff + CW'(1);
                  end
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  pend_status_in = STAT_EMPTY;
                  state_in       = S_DONE;
               end else begin
                  scan_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_take) begin
               best_in      = scan_ff;
               best_prio_in = head.prio;
               pend_tag_in  = head.tag;
               pend_prio_in = head.prio;
            end
            if (scan_last) begin
               state_in = S_SHIFT;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_SHIFT: begin
            count_in       = count_ff - CW'(1);
            pend_status_in = STAT_SERVED;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_tag_in    = pend_tag_ff;
               rsp_prio_in   = pend_prio_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      best_ff        <= best_in;
      best_prio_ff   <= best_prio_in;
      pend_status_ff <= pend_status_in;
      pend_tag_ff    <= pend_tag_in;
      pend_prio_ff   <= pend_prio_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign ctrl.load_en  = accept && is_add && !full;
   assign ctrl.scan_en  = (state_ff == S_SCAN);
   assign ctrl.shift_en = (state_ff == S_SHIFT);
   assign count         = count_ff;
   assign best          = best_ff;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.served_tag      = rsp_tag_ff;
   assign rsp_chan.served_priority = rsp_prio_ff;
   assign rsp_chan.occupancy       = rsp_occ_ff;

endmodule

[rtl/stable_priority_queue_core.sv]
// Top level of the stable priority queue: a row of entry cells and its sequencer.
// Depends on spq_pkg, spq_if, spq_cell and spq_ctrl.
//
// Usage:
//   req_chan carries one request per transfer: action (add or serve), a 16-bit
//   tag and a 2-bit priority. rsp_chan returns exactly one response per request:
//   status, served tag and priority (zero unless served) and the occupancy after
//   the request.
//   Entries sit in a row of QUEUE_DEPTH cells in arrival order. An add loads the
//   cell at the current count in the transfer cycle. A serve rotates the whole
//   row once past a comparator at cell 0 to find the oldest entry of lowest
//   priority, then the cells behind it move up one place.
//   From request transfer, an add or an empty serve goes to S_DONE and a serve
//   through S_SCAN and S_SHIFT to S_DONE, which loads the response register;
//   one request is in work at a time: req_chan.ready is high only in S_IDLE.
//   The response sits in an output register; a new request is taken while it
//   waits, and the next response waits in the sequencer until rsp_chan.ready.
//   Synchronous reset empties the queue and drops any pending response; cell
//   contents are not cleared.

module stable_priority_queue_core import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   ctrl_type      ctrl;
   logic [CW-1:0] count;
   logic [IW-1:0] best;
   entry_type     new_entry;
   entry_type     cell_data [QUEUE_DEPTH];
   cell_ctl_type  cell_ctl  [QUEUE_DEPTH];

   assign new_entry.tag  = req_chan.request_tag;
   assign new_entry.prio = req_chan.request_priority;

   spq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .head     (cell_data[0]),
      .ctrl     (ctrl),
      .count    (count),
      .best     (best)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign cell_ctl[i].load    = ctrl.load_en && (count == CW'(i));
      assign cell_ctl[i].advance = ctrl.scan_en || (ctrl.shift_en && (best <= IW'(i)));

      spq_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .load_data (new_entry),
         .next_data (cell_data[(i + 1) % QUEUE_DEPTH]),
         .data      (cell_data[i])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(QUEUE_DEPTH))
      else $error("entry count above depth");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_en |-> (count < CW'(QUEUE_DEPTH)))
      else $error("load into full queue");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift_en |-> (count != '0) && (CW'(best) < count))
      else $error("removal with no entry at chosen slot");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second request taken while one is in work");

endmodule

[verif/tb_stable_priority_queue_core.sv]
// Testbench for stable_priority_queue_core: directed table, then randomized add/serve traffic
// checked against a behavioral queue model, with random idling on both channels.
// Depends on spq_pkg, spq_if and the stable_priority_queue_core RTL.

module tb_stable_priority_queue_core;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = 8;
   localparam int RANDOM_ITEMS = 1800;
   localparam int PHASE_LEN    = 150;
   localparam int LONG_HOLD    = 100;

   typedef struct {
      logic              action;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } queue_request_type;

   typedef struct {
      status_type        status;
      logic [TAG_W-1:0]  served_tag;
      logic [PRIO_W-1:0] served_priority;
      logic [OCC_W-1:0]  occupancy;
   } queue_result_type;

   typedef struct packed {
      logic              action;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic              fixed;
      status_type        want_status;
      logic [OCC_W-1:0]  want_occ;
   } directed_row_type;

   // fixed rows carry their expected status and occupancy; the rest use the model
   localparam directed_row_type DIRECTED_ROWS [21] = '{
      '{ACT_SERVE, 16'hFFFF, 2'd3, 1'b1, STAT_EMPTY, 4'd0},
      '{ACT_ADD,   16'hFFFF, 2'd3, 1'b1, STAT_ADDED, 4'd1},
      '{ACT_ADD,   16'h0000, 2'd0, 1'b1, STAT_ADDED, 4'd2},
      '{ACT_ADD,   16'h8001, 2'd1, 1'b1, STAT_ADDED, 4'd3},
      '{ACT_ADD,   16'h0001, 2'd0, 1'b1, STAT_ADDED, 4'd4},
      '{ACT_ADD,   16'hAAAA, 2'd2, 1'b1, STAT_ADDED, 4'd5},
      '{ACT_ADD,   16'h5555, 2'd1, 1'b1, STAT_ADDED, 4'd6},
      '{ACT_ADD,   16'h7FFF, 2'd3, 1'b1, STAT_ADDED, 4'd7},
      '{ACT_ADD,   16'h0002, 2'd0, 1'b1, STAT_ADDED, 4'd8},
      '{ACT_ADD,   16'h1234, 2'd0, 1'b1, STAT_FULL,  4'd8},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'hFFFF, 2'd3, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'h5A5A, 2'd1, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'hA5A5, 2'd2, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b0, STAT_SERVED, 4'd0},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b1, STAT_EMPTY,  4'd0},
      '{ACT_ADD,   16'hBEEF, 2'd2, 1'b1, STAT_ADDED,  4'd1},
      '{ACT_SERVE, 16'h0000, 2'd0, 1'b0, STAT_SERVED, 4'd0}
   };

   logic clock;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   stable_priority_queue_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   entry_type        held_entries [QUEUE_DEPTH];
   int unsigned      held_count = 0;
   queue_result_type results_due [$];
   int               mismatch_count = 0;
   int               responses_seen = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic queue_result_type apply_request(queue_request_type req);
      queue_result_type res;
      int unsigned      best;
      entry_type        chosen;
      res.status          = STAT_ADDED;
      res.served_tag      = '0;
      res.served_priority = '0;
      if (req.action == ACT_ADD) begin
         if (held_count >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
         end else begin
            held_entries[held_count].prio = req.prio;
            held_entries[held_count].tag  = req.tag;
            held_count++;
         end
      end else if (held_count == 0) begin
         res.status = STAT_EMPTY;
      end else begin
         best = 0;
         for (int unsigned i = 1; i < held_count; i++)
            if (held_entries[i].prio < held_entries[best].prio) best = i;
         chosen = held_entries[best];
         for (int unsigned i = best; i + 1 < held_count; i++)
            held_entries[i] = held_entries[i + 1];
         held_count--;
         res.status          = STAT_SERVED;
         res.served_tag      = chosen.tag;
         res.served_priority = chosen.prio;
      end
      res.occupancy = OCC_W'(held_count);
      return res;
   endfunction

   function automatic int pick_gap(bit bursty);
      int r;
      r = $urandom_range(0, 99);
      if (bursty || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return TAG_W'($urandom);
   endfunction

   task automatic idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid            <= 1'b0;
         req_chan.action           <= 1'($urandom_range(0, 1));
         req_chan.request_tag      <= TAG_W'($urandom);
         req_chan.request_priority <= PRIO_W'($urandom);
      end
   endtask

   // present one request and return once its transfer has happened
   task automatic offer(queue_request_type req);
      @(negedge clock);
      req_chan.valid            <= 1'b1;
      req_chan.action           <= req.action;
      req_chan.request_tag      <= req.tag;
      req_chan.request_priority <= req.prio;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   initial begin : stimulus
      queue_request_type req;
      queue_result_type  res;
      int                add_pct;
      int                prio_lo;
      int                prio_hi;
      bit                bursty;
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.action           <= ACT_ADD;
      req_chan.request_tag      <= '0;
      req_chan.request_priority <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[n]) begin
         req.action = DIRECTED_ROWS[n].action;
         req.tag    = DIRECTED_ROWS[n].tag;
         req.prio   = DIRECTED_ROWS[n].prio;
         offer(req);
         res = apply_request(req);
         if (DIRECTED_ROWS[n].fixed) begin
            res.status          = DIRECTED_ROWS[n].want_status;
            res.served_tag      = '0;
            res.served_priority = '0;
            res.occupancy       = DIRECTED_ROWS[n].want_occ;
         end
         results_due.push_back(res);
         idle(pick_gap(1'b0));
      end

      add_pct = 50;
      prio_lo = 0;
      prio_hi = 3;
      bursty  = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            add_pct = $urandom_range(15, 90);
            if ((n / PHASE_LEN) % 2 == 0) begin
               prio_lo = 0;
               prio_hi = 3;
            end else begin
               prio_lo = $urandom_range(0, 3);
               prio_hi = $urandom_range(prio_lo, 3);
            end
            bursty = ($urandom_range(0, 3) == 0);
         end
         // drain completely once mid-run
         if (n == RANDOM_ITEMS / 2) begin
            do idle(1); while (results_due.size() != 0);
         end
         req.action = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_SERVE;
         req.tag    = pick_tag();
         req.prio   = PRIO_W'($urandom_range(prio_lo, prio_hi));
         offer(req);
         results_due.push_back(apply_request(req));
         idle(pick_gap(bursty));
      end
      idle(1);

      while (results_due.size() != 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : rsp_ready_driver
      bit level;
      bit long_hold_done;
      int span;
      int r;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (!long_hold_done && responses_seen >= 500) begin
            // long backpressure so the core fills and stalls its input
            level          = 1'b0;
            span           = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (r < 55) begin
            level = 1'b1;
            span  = $urandom_range(1, 40);
         end else if (r < 92) begin
            level = 1'b0;
            span  = $urandom_range(1, 3);
         end else begin
            level = 1'b0;
            span  = $urandom_range(8, 30);
         end
         repeat (span) begin
            @(negedge clock);
            rsp_chan.ready <= level;
         end
      end
   end

   always @(posedge clock) begin : result_check
      queue_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         responses_seen++;
         if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: status=%0d tag=%h prio=%0d occ=%0d",
                        rsp_chan.status, rsp_chan.served_tag, rsp_chan.served_priority,
                        rsp_chan.occupancy);
         end else begin
            want = results_due.pop_front();
            if (rsp_chan.status !== 2'(want.status) ||
                rsp_chan.served_tag !== want.served_tag ||
                rsp_chan.served_priority !== want.served_priority ||
                rsp_chan.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status=%0d tag=%h prio=%0d occ=%0d, %s",
                           want.status, want.served_tag, want.served_priority,
                           want.occupancy,
                           $sformatf("got status=%0d tag=%h prio=%0d occ=%0d",
                                     rsp_chan.status, rsp_chan.served_tag,
                                     rsp_chan.served_priority, rsp_chan.occupancy));
            end
         end
      end
   end

endmodule
